// File: rtl/tsf_pkg.sv
`default_nettype none

package tsf_pkg;

   // telnet command and option bytes
   localparam logic [7:0] B_IAC      = 8'd255;
   localparam logic [7:0] B_SB       = 8'd250;
   localparam logic [7:0] B_SE       = 8'd240;
   localparam logic [7:0] B_WILL     = 8'd251;
   localparam logic [7:0] B_WONT     = 8'd252;
   localparam logic [7:0] B_DO       = 8'd253;
   localparam logic [7:0] B_DONT     = 8'd254;
   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;
   localparam logic [7:0] OPT_TTYPE  = 8'd24;
   localparam logic [7:0] OPT_TSPEED = 8'd32;
   localparam logic [7:0] OPT_NAWS   = 8'd31;

   // plain characters
   localparam logic [7:0] CH_BS      = 8'd8;
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_TILDE   = 8'd126;
   localparam logic [7:0] CH_HASH    = 8'd35;

   // result kinds
   localparam logic [1:0] K_PEER     = 2'd0;
   localparam logic [1:0] K_LINE     = 2'd1;
   localparam logic [1:0] K_PROMPT   = 2'd2;
   localparam logic [1:0] K_WIN      = 2'd3;

   // result word: byte, cols, rows
   localparam int TDATA_W = 40;

   // what a received byte asks the output side to do
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_HASH,
      ACT_ERASE,
      ACT_REPLY,
      ACT_NAWS,
      ACT_LINE,
      ACT_PROMPT
   } act_type;

   typedef struct packed {
      act_type     act;
      logic [7:0]  verb;
      logic [7:0]  opt;
      logic [15:0] cols;
      logic [15:0] rows;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/tsf_ram.sv
`default_nettype none

module tsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/tsf_parse.sv
`default_nettype none

module tsf_parse #(
   parameter int LINE_CAPACITY = 48,
   parameter int SUB_CAPACITY  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_fire,
   input  wire logic [7:0]                          in_byte,
   output tsf_pkg::cmd_type                         cmd,
   output logic [$clog2(LINE_CAPACITY+1)-1:0]       walk_len,
   output logic                                     wr_en,
   output logic [$clog2(LINE_CAPACITY)-1:0]         wr_addr,
   output logic [7:0]                               wr_data
);

   import tsf_pkg::*;

   localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W = $clog2(LINE_CAPACITY);
   localparam int SUB_W  = $clog2(SUB_CAPACITY + 1);

   typedef enum logic [2:0] {
      PS_NORMAL,
      PS_IAC,
      PS_OPT,
      PS_SB,
      PS_DAT,
      PS_SE
   } pstate_type;

   pstate_type       pstate_ff, pstate_in;
   logic [7:0]       verb_ff, verb_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [SUB_W-1:0] sub_cnt_ff, sub_cnt_in;
   logic [7:0]       sub_ff [4];
   logic             sub_wr;
   logic             store;
   logic             room;

   assign room    = len_ff < LEN_W'(LINE_CAPACITY);
   assign wr_en   = in_fire && store && room;
   assign wr_addr = len_ff[ADDR_W-1:0];
   assign wr_data = in_byte;

   // byte decode
   always_comb begin
      pstate_in  = pstate_ff;
      verb_in    = verb_ff;
      len_in     = len_ff;
      sub_cnt_in = sub_cnt_ff;
      sub_wr     = 1'b0;
      store      = 1'b0;
      walk_len   = '0;
      cmd.act    = ACT_NONE;
      cmd.verb   = B_DO;
      cmd.opt    = in_byte;
      cmd.cols   = {sub_ff[0], sub_ff[1]};
      cmd.rows   = {sub_ff[2], sub_ff[3]};
      case (pstate_ff)
         PS_NORMAL: begin
            if (in_byte == B_IAC) begin
               pstate_in = PS_IAC;
            end else if (in_byte == CH_BS) begin
               if (len_ff != '0) begin
                  len_in  = len_ff - LEN_W'(1);
                  cmd.act = ACT_ERASE;
               end else begin
                  cmd.act = ACT_HASH;
               end
            end else if (in_byte == CH_LF) begin
               len_in = '0;
               if (len_ff != '0 && room) begin
                  walk_len = len_ff;
                  cmd.act  = ACT_LINE;
               end else begin
                  cmd.act  = ACT_PROMPT;
               end
            end else if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) begin
               store = 1'b1;
            end
         end
         PS_IAC: begin
            if (in_byte == B_IAC) begin
               store     = 1'b1;
               pstate_in = PS_NORMAL;
            end else if (in_byte >= B_WILL) begin
               verb_in   = in_byte;
               pstate_in = PS_OPT;
            end else if (in_byte == B_SB) begin
               pstate_in = PS_SB;
            end else begin
               pstate_in = PS_NORMAL;
            end
         end
         PS_OPT: begin
            pstate_in = PS_NORMAL;
            if (in_byte == OPT_ECHO || in_byte == OPT_SGA || in_byte == OPT_NAWS) begin
               cmd.act = ACT_NONE;
            end else if (in_byte == OPT_TTYPE || in_byte == OPT_TSPEED) begin
               cmd.act  = ACT_REPLY;
               cmd.verb = B_DO;
            end else if (verb_ff == B_WILL || verb_ff == B_WONT) begin
               cmd.act  = ACT_REPLY;
               cmd.verb = B_DONT;
            end else begin
               cmd.act  = ACT_REPLY;
               cmd.verb = B_WONT;
            end
         end
         PS_SB: begin
            verb_in    = in_byte;
            sub_cnt_in = '0;
            pstate_in  = PS_DAT;
         end
         PS_DAT: begin
            if (in_byte == B_IAC) begin
               pstate_in = PS_SE;
            end else if (sub_cnt_ff < SUB_W'(SUB_CAPACITY)) begin
               sub_wr     = sub_cnt_ff < SUB_W'(4);
               sub_cnt_in = sub_cnt_ff + SUB_W'(1);
            end
         end
         PS_SE: begin
            pstate_in = PS_NORMAL;
            if (in_byte == B_SE && verb_ff == OPT_NAWS && sub_cnt_ff == SUB_W'(4)) begin
               cmd.act = ACT_NAWS;
            end
         end
         default: begin
            pstate_in = PS_NORMAL;
         end
      endcase
      if (store && room) begin
         len_in = len_ff + LEN_W'(1);
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         pstate_ff  <= PS_NORMAL;
         verb_ff    <= '0;
         len_ff     <= '0;
         sub_cnt_ff <= '0;
      end else if (in_fire) begin
         pstate_ff  <= pstate_in;
         verb_ff    <= verb_in;
         len_ff     <= len_in;
         sub_cnt_ff <= sub_cnt_in;
      end
   end

   // first four subnegotiation bytes
   always_ff @(posedge clock) begin
      if (in_fire && sub_wr) begin
         sub_ff[sub_cnt_ff[1:0]] <= in_byte;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tsf_seq.sv
`default_nettype none

module tsf_seq #(
   parameter int LINE_CAPACITY = 48
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_fire,
   input  wire tsf_pkg::cmd_type                    cmd,
   input  wire logic [$clog2(LINE_CAPACITY+1)-1:0]  walk_len,
   output logic                                     in_ready,
   output logic [$clog2(LINE_CAPACITY)-1:0]         rd_addr,
   input  wire logic [7:0]                          rd_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_kind,
   output logic [7:0]                               rsp_byte,
   output logic [15:0]                              rsp_cols,
   output logic [15:0]                              rsp_rows,
   output logic                                     rsp_last
);

   import tsf_pkg::*;

   localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W = $clog2(LINE_CAPACITY);

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_EMIT,
      SQ_FETCH,
      SQ_LINE
   } sq_type;

   sq_type            state_ff;
   cmd_type           cmd_ff;
   cmd_type           cmd_in;
   logic [1:0]        step_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [LEN_W-1:0]  walk_len_ff;
   logic              valid_ff;
   logic [1:0]        kind_ff;
   logic [7:0]        byte_ff;
   logic [15:0]       cols_ff;
   logic [15:0]       rows_ff;
   logic              last_ff;

   logic              out_free;
   logic              load;
   logic              load_last;
   logic [1:0]        kind_in;
   logic [7:0]        byte_in;
   logic [15:0]       cols_in;
   logic [15:0]       rows_in;
   logic [1:0]        final_step;
   logic              line_end;

   assign out_free = !valid_ff || rsp_ready;
   assign in_ready = state_ff == SQ_IDLE;
   assign rd_addr  = idx_ff;
   assign line_end = (LEN_W'(idx_ff) + LEN_W'(1)) == walk_len_ff;

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_cols  = cols_ff;
   assign rsp_rows  = rows_ff;
   assign rsp_last  = last_ff;

   // a line walk finishes with the prompt word
   always_comb begin
      cmd_in = cmd;
      if (cmd.act == ACT_LINE) begin
         cmd_in.act = ACT_PROMPT;
      end
   end

   // result word for the current step
   always_comb begin
      kind_in    = K_PEER;
      byte_in    = '0;
      cols_in    = '0;
      rows_in    = '0;
      final_step = 2'd0;
      case (cmd_ff.act)
         ACT_HASH: begin
            byte_in = CH_HASH;
         end
         ACT_ERASE: begin
            byte_in    = step_ff[0] ? CH_BS : CH_SPACE;
            final_step = 2'd3;
         end
         ACT_REPLY: begin
            final_step = 2'd2;
            case (step_ff)
               2'd0:    byte_in = B_IAC;
               2'd1:    byte_in = cmd_ff.verb;
               default: byte_in = cmd_ff.opt;
            endcase
         end
         ACT_NAWS: begin
            kind_in = K_WIN;
            cols_in = cmd_ff.cols;
            rows_in = cmd_ff.rows;
         end
         default: begin
            kind_in = K_PROMPT;
         end
      endcase
      if (state_ff == SQ_LINE) begin
         kind_in = K_LINE;
         byte_in = rd_data;
         cols_in = '0;
         rows_in = '0;
      end
   end

   assign load      = out_free && (state_ff == SQ_EMIT || state_ff == SQ_LINE);
   assign load_last = state_ff == SQ_EMIT && step_ff == final_step;

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         valid_ff <= 1'b0;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            SQ_IDLE: begin
               step_ff <= '0;
               idx_ff  <= '0;
               if (in_fire && cmd.act == ACT_LINE) begin
                  state_ff <= SQ_FETCH;
               end else if (in_fire && cmd.act != ACT_NONE) begin
                  state_ff <= SQ_EMIT;
               end
            end
            SQ_EMIT: begin
               if (load) begin
                  step_ff <= step_ff + 2'd1;
                  if (load_last) begin
                     state_ff <= SQ_IDLE;
                  end
               end
            end
            SQ_FETCH: begin
               state_ff <= SQ_LINE;
            end
            SQ_LINE: begin
               if (load) begin
                  if (line_end) begin
                     state_ff <= SQ_EMIT;
                  end else begin
                     idx_ff   <= idx_ff + ADDR_W'(1);
                     state_ff <= SQ_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= SQ_IDLE;
            end
         endcase
      end
      if (in_fire) begin
         cmd_ff      <= cmd_in;
         walk_len_ff <= walk_len;
      end
      if (load) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         last_ff <= load_last;
      end
   end

`ifndef SYNTHESIS
   a_line_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQ_LINE) |-> (LEN_W'(idx_ff) < walk_len_ff))
      else $error("line walk index past stored length");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |=> (state_ff == SQ_IDLE))
      else $error("sequencer busy after final word");

   a_line_start: assert property (@(posedge clock) disable iff (reset)
      (in_fire && cmd.act == ACT_LINE) |=> (state_ff == SQ_FETCH && idx_ff == '0))
      else $error("line walk did not start at entry zero");
`endif

endmodule

`default_nettype wire

// File: rtl/telnet_stream_filter_top.sv
// channel   dir  tdata                        tuser      tlast
// req_      in   [7:0] data_in                -          -
// rsp_      out  [7:0] byte_out, [23:8] cols, [1:0] kind last
//                [39:24] rows
//
// a byte that causes no word leaves the block idle; req_tready stays high
// words to the peer go out back to back while rsp_tready is high
// newline walks the line memory, for each stored byte a read, then a send
// reset clears the parser and sequencer; the line memory is not cleared,
// its fill count alone says which entries hold data
// a stalled rsp_ side holds the sequencer, req_tready stays low until done
`default_nettype none

module telnet_stream_filter_top #(
   parameter int LINE_CAPACITY = 48,
   parameter int SUB_CAPACITY  = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,   // [7:0] data_in
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [tsf_pkg::TDATA_W-1:0]       rsp_tdata,   // byte_out, cols, rows
   output logic [1:0]                        rsp_tuser,   // kind
   output logic                              rsp_tlast    // last
);

   import tsf_pkg::*;

   localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W = $clog2(LINE_CAPACITY);

   logic              in_fire;
   cmd_type           cmd;
   logic [LEN_W-1:0]  walk_len;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [7:0]        rsp_byte;
   logic [15:0]       rsp_cols;
   logic [15:0]       rsp_rows;

   assign in_fire   = req_tvalid && req_tready;
   assign rsp_tdata = {rsp_rows, rsp_cols, rsp_byte};

   // byte parser and negotiation state
   tsf_parse #(
      .LINE_CAPACITY (LINE_CAPACITY),
      .SUB_CAPACITY  (SUB_CAPACITY)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (in_fire),
      .in_byte  (req_tdata),
      .cmd      (cmd),
      .walk_len (walk_len),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   // command line memory
   tsf_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CAPACITY)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word sequencer with output register
   tsf_seq #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .cmd       (cmd),
      .walk_len  (walk_len),
      .in_ready  (req_tready),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_byte  (rsp_byte),
      .rsp_cols  (rsp_cols),
      .rsp_rows  (rsp_rows),
      .rsp_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: tb/sv/telnet_stream_filter_top_tb.sv
`timescale 1ns / 1ps

module telnet_stream_filter_top_tb;

   import tsf_pkg::*;

   localparam int LINE_CAP       = 48;
   localparam int SUB_CAP        = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   // one word towards the peer or the shell, as the block should send it
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] cols;
      logic [15:0] rows;
      logic        last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      PS_DATA,
      PS_CMD,
      PS_OPTION,
      PS_SB_OPTION,
      PS_SB_DATA,
      PS_SB_IAC
   } parse_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = 8'd0;  // [7:0] data_in
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;          // [7:0] byte_out, [23:8] cols, [39:24] rows
   logic [1:0]          rsp_tuser;          // [1:0] kind
   logic                rsp_tlast;

   // stimulus and expectations
   logic [7:0]    rx_bytes [$];
   logic [7:0]    opening_bytes [$];
   rsp_word_type  expected_words [$];
   int            stim_count    = 0;
   int            send_idle_pct = 29;
   int            recv_idle_pct = 46;
   int            error_count   = 0;
   int            quiet_cycles  = 0;

   // shadow of the parser and line editor
   parse_type   ps;
   logic [7:0]  held_verb;
   logic [7:0]  line_buf [0:LINE_CAP-1];
   int          line_len;
   logic [7:0]  sub_buf [0:3];
   int          sub_len;

   telnet_stream_filter_top #(
      .LINE_CAPACITY (LINE_CAP),
      .SUB_CAPACITY  (SUB_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic void add_word(input logic [1:0] k, input logic [7:0] b,
                                    input logic [15:0] c, input logic [15:0] r);
      expected_words.push_back('{k, b, c, r, 1'b0});
   endfunction

   function automatic void reply_to_peer(input logic [7:0] verb, input logic [7:0] opt);
      add_word(K_PEER, B_IAC, 16'd0, 16'd0);
      add_word(K_PEER, verb, 16'd0, 16'd0);
      add_word(K_PEER, opt, 16'd0, 16'd0);
   endfunction

   function automatic void store_char(input logic [7:0] ch);
      if (line_len < LINE_CAP) begin
         line_buf[line_len] = ch;
         line_len++;
      end
   endfunction

   // expected words for one received byte, last flag on the final one
   function automatic void filter_byte(input logic [7:0] rx);
      int           first;
      int           i;
      rsp_word_type w;
      first = expected_words.size();
      case (ps)
         PS_DATA: begin
            if (rx == B_IAC) begin
               ps = PS_CMD;
            end else if (rx == CH_BS) begin
               if (line_len > 0) begin
                  line_len--;
                  add_word(K_PEER, CH_SPACE, 16'd0, 16'd0);
                  add_word(K_PEER, CH_BS, 16'd0, 16'd0);
                  add_word(K_PEER, CH_SPACE, 16'd0, 16'd0);
                  add_word(K_PEER, CH_BS, 16'd0, 16'd0);
               end else begin
                  add_word(K_PEER, CH_HASH, 16'd0, 16'd0);
               end
            end else if (rx == CH_LF) begin
               // a full line is dropped
               if (line_len > 0 && line_len < LINE_CAP) begin
                  for (i = 0; i < line_len; i++)
                     add_word(K_LINE, line_buf[i], 16'd0, 16'd0);
               end
               line_len = 0;
               add_word(K_PROMPT, 8'd0, 16'd0, 16'd0);
            end else if (rx >= CH_SPACE && rx <= CH_TILDE) begin
               store_char(rx);
            end
         end
         PS_CMD: begin
            if (rx == B_IAC) begin
               store_char(rx);
               ps = PS_DATA;
            end else if (rx >= B_WILL && rx <= B_DONT) begin
               held_verb = rx;
               ps = PS_OPTION;
            end else if (rx == B_SB) begin
               ps = PS_SB_OPTION;
            end else begin
               ps = PS_DATA;
            end
         end
         PS_OPTION: begin
            if (rx == OPT_ECHO || rx == OPT_SGA || rx == OPT_NAWS) begin
               // accepted silently
            end else if (rx == OPT_TTYPE || rx == OPT_TSPEED) begin
               reply_to_peer(B_DO, rx);
            end else if (held_verb == B_WILL || held_verb == B_WONT) begin
               reply_to_peer(B_DONT, rx);
            end else begin
               reply_to_peer(B_WONT, rx);
            end
            ps = PS_DATA;
         end
         PS_SB_OPTION: begin
            held_verb = rx;
            sub_len = 0;
            ps = PS_SB_DATA;
         end
         PS_SB_DATA: begin
            if (rx == B_IAC) begin
               ps = PS_SB_IAC;
            end else if (sub_len < SUB_CAP) begin
               if (sub_len < 4)
                  sub_buf[sub_len] = rx;
               sub_len++;
            end
         end
         PS_SB_IAC: begin
            if (rx == B_SE && held_verb == OPT_NAWS && sub_len == 4)
               add_word(K_WIN, 8'd0, {sub_buf[0], sub_buf[1]}, {sub_buf[2], sub_buf[3]});
            ps = PS_DATA;
         end
         default: ps = PS_DATA;
      endcase
      if (expected_words.size() > first) begin
         w = expected_words.pop_back();
         w.last = 1'b1;
         expected_words.push_back(w);
      end
   endfunction

   // stimulus builders
   function automatic void send_byte(input logic [7:0] b);
      rx_bytes.push_back(b);
      stim_count++;
   endfunction

   function automatic void send_line(input int len, input bit with_edits);
      int i;
      for (i = 0; i < len; i++) begin
         if (with_edits && $urandom_range(9) == 0) begin
            send_byte(B_IAC);
            send_byte(B_IAC);
         end else begin
            send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
         end
         if (with_edits && $urandom_range(7) == 0)
            send_byte(CH_BS);
      end
      send_byte(CH_LF);
   endfunction

   function automatic void send_negotiation();
      logic [7:0] opt;
      case ($urandom_range(6))
         0:       opt = OPT_ECHO;
         1:       opt = OPT_SGA;
         2:       opt = OPT_NAWS;
         3:       opt = OPT_TTYPE;
         4:       opt = OPT_TSPEED;
         default: opt = 8'($urandom_range(255));
      endcase
      send_byte(B_IAC);
      send_byte(8'($urandom_range(B_WILL, B_DONT)));
      send_byte(opt);
   endfunction

   function automatic void send_subneg(input int len);
      int i;
      send_byte(B_IAC);
      send_byte(B_SB);
      send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : OPT_NAWS);
      for (i = 0; i < len; i++)
         send_byte(8'($urandom_range(254)));
      send_byte(B_IAC);
      send_byte(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : B_SE);
   endfunction

   // mostly well-formed sequences with random content, some noise
   function automatic void send_random(input int count);
      int target;
      int sel;
      int i;
      target = stim_count + count;
      while (stim_count < target) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            send_line(($urandom_range(6) == 0) ? $urandom_range(40, 52) : $urandom_range(8), 1'b1);
         end else if (sel < 60) begin
            send_negotiation();
         end else if (sel < 75) begin
            send_subneg(($urandom_range(1) == 0) ? 4 : $urandom_range(6));
         end else if (sel < 85) begin
            for (i = 0; i < $urandom_range(1, 4); i++)
               send_byte(8'($urandom_range(255)));
         end else if (sel < 92) begin
            for (i = 0; i < $urandom_range(1, 3); i++)
               send_byte(CH_BS);
         end else begin
            send_byte(B_IAC);
            send_byte(8'($urandom_range(255)));
         end
      end
   endfunction

   // sender: next byte when the slot is free, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'd0;
      end else if (!req_tvalid || req_tready) begin
         if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= rx_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: predicts on accepted bytes, checks accepted words, drives rsp_tready
   always @(posedge clock) begin
      rsp_word_type exp_w;
      rsp_word_type got_w;
      if (reset) begin
         rsp_tready   <= 1'b0;
         ps           = PS_DATA;
         held_verb    = 8'd0;
         line_len     = 0;
         sub_len      = 0;
         quiet_cycles = 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_tvalid && req_tready)
            filter_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got_w = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8], rsp_tdata[39:24], rsp_tlast};
            if (expected_words.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected word: kind %0d byte %02h cols %0d rows %0d last %0b",
                           got_w.kind, got_w.data, got_w.cols, got_w.rows, got_w.last);
               error_count++;
            end else begin
               exp_w = expected_words.pop_front();
               if (got_w != exp_w) begin
                  if (error_count < 10)
                     $display({"mismatch: expected kind %0d byte %02h cols %0d rows %0d last %0b,",
                               " got kind %0d byte %02h cols %0d rows %0d last %0b"},
                              exp_w.kind, exp_w.data, exp_w.cols, exp_w.rows, exp_w.last,
                              got_w.kind, got_w.data, got_w.cols, got_w.rows, got_w.last);
                  error_count++;
               end
            end
         end
         // watchdog on cycles without any handshake
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("telnet_stream_filter_top_tb NOT OK");
            $finish;
         end
      end
   end

   // wait until every byte is taken and every word has come back
   task automatic drain();
      while (rx_bytes.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      // corner cases: erase on empty line, escaped IAC, ignored bytes, every verb,
      // unknown command and a window size report
      opening_bytes = '{CH_BS, 8'd65, B_IAC, B_IAC, CH_TILDE, CH_SPACE, 8'd0, 8'd127,
                        8'd200, CH_BS, CH_LF, CH_LF,
                        B_IAC, B_WILL, OPT_TTYPE, B_IAC, B_WONT, 8'd5,
                        B_IAC, B_DO, OPT_ECHO, B_IAC, B_DONT, 8'd0, B_IAC, 8'd100,
                        B_IAC, B_SB, OPT_NAWS, 8'd0, 8'd80, 8'd0, 8'd24, B_IAC, B_SE};
      foreach (opening_bytes[i])
         send_byte(opening_bytes[i]);
      send_random(10);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      drain();

      // swapped gaps; a full line and an overlong subnegotiation
      send_idle_pct = 46;
      recv_idle_pct = 29;
      send_line(LINE_CAP, 1'b0);
      send_subneg(SUB_CAP + 1);
      send_random(10);
      drain();

      // back to back on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(10);
      drain();

      if (expected_words.size() != 0)
         error_count++;
      if (error_count == 0)
         $display("telnet_stream_filter_top_tb OK");
      else
         $display("telnet_stream_filter_top_tb NOT OK");
      $finish;
   end

endmodule

// File: filelist.f
rtl/tsf_pkg.sv
rtl/tsf_ram.sv
rtl/tsf_parse.sv
rtl/tsf_seq.sv
rtl/telnet_stream_filter_top.sv
tb/sv/telnet_stream_filter_top_tb.sv
